// File: src/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants and types of the sorted table: opcodes, status codes and
// the control word that travels down the cell chain with each request.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int DEF_TABLE_DEPTH = 256;

    localparam int VALUE_W = 32;
    localparam int FIELD_W = 9;   // width of position and entry_count ports

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // control word of a request token
    typedef struct packed {
        logic valid;      // token slot holds a request
        logic op;         // OP_INSERT or OP_SEARCH
        logic shifting;   // insert already placed, cells now shift right
        logic found;      // search has met an equal entry
        logic full;       // table was full when the request was taken
    } sts_tok_t;

endpackage

// File: src/sts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_req_if / sts_rsp_if
// Valid/ready channels of the sorted table: request and response.
// ----------------------------------------------------------------------------
interface sts_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [sts_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [sts_pkg::FIELD_W-1:0]   position;
    logic [sts_pkg::FIELD_W-1:0]   entry_count;
    logic                          status;

    modport source (output valid, output found, output position, output entry_count,
                    output status, input ready);
    modport sink   (input valid, input found, input position, input entry_count,
                    input status, output ready);
endinterface

// File: src/sorted_table_insert_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// Sorted table of signed 32-bit values built as a chain of shift cells.
// Inserts go in upper-bound order, searches report the lower bound.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   request
//  -------  ---  ----------------------------------------  --------------------
//  req      in   opcode, value                             insert or search
//  rsp      out  found, position, entry_count, status      one per request
//
//  One request enters per cycle while the chain advances. Each request walks
//  the cell chain one cell per cycle, then passes the response register.
//  Reset clears the entry count and all token slots; entry storage is not
//  cleared and needs no clearing pass.
//  When the response register holds an untaken response, the whole chain
//  freezes and req.ready drops until rsp.ready returns.
//
module sorted_table_insert_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sts_req_if.sink     req,
    sts_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    // wide enough for both the internal count and the fixed port fields
    localparam int EXT_W = (CNT_W > sts_pkg::FIELD_W) ? CNT_W : sts_pkg::FIELD_W;

    // token chain: index 0 feeds cell 0, index TABLE_DEPTH leaves the last cell
    sts_pkg::sts_tok_t                  tok  [TABLE_DEPTH+1];
    logic signed [sts_pkg::VALUE_W-1:0] key  [TABLE_DEPTH+1];
    logic signed [sts_pkg::VALUE_W-1:0] carry[TABLE_DEPTH+1];
    logic [CNT_W-1:0]                   pos  [TABLE_DEPTH+1];
    logic [CNT_W-1:0]                   cnt  [TABLE_DEPTH+1];

    logic             adv;
    logic             accept;
    logic             table_full;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    logic             out_found_reg;
    logic             out_status_reg;
    logic [CNT_W-1:0] out_pos_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             tail_insert;
    logic             tail_grow;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] cnt_ext;

    // chain moves whenever the response register is free or being emptied
    assign adv        = !out_valid_reg || rsp.ready;
    assign req.ready  = adv;
    assign accept     = req.valid && adv;
    assign table_full = count_reg == CNT_W'(TABLE_DEPTH);

    // entry count is settled at accept; every token carries the count it saw
    always_comb
    begin
        count_next = count_reg;
        if (accept && req.opcode == sts_pkg::OP_INSERT && !table_full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // new token enters at the head; a bubble when nothing is taken
    always_comb
    begin
        tok[0].valid    = accept;
        tok[0].op       = req.opcode;
        tok[0].shifting = 1'b0;
        tok[0].found    = 1'b0;
        tok[0].full     = table_full;
    end
    assign key[0]   = req.value;
    assign carry[0] = req.value;
    assign pos[0]   = '0;
    assign cnt[0]   = count_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        sts_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .tok_in    (tok[i]),
            .key_in    (key[i]),
            .carry_in  (carry[i]),
            .pos_in    (pos[i]),
            .cnt_in    (cnt[i]),
            .tok_out   (tok[i+1]),
            .key_out   (key[i+1]),
            .carry_out (carry[i+1]),
            .pos_out   (pos[i+1]),
            .cnt_out   (cnt[i+1])
        );
    end

    // tail of the chain: finish the response fields
    assign tail_insert = tok[TABLE_DEPTH].op == sts_pkg::OP_INSERT;
    assign tail_grow   = tail_insert && !tok[TABLE_DEPTH].full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tok[TABLE_DEPTH].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_found_reg  <= tok[TABLE_DEPTH].found && !tail_insert;
            out_status_reg <= (tail_insert && tok[TABLE_DEPTH].full) ?
                              sts_pkg::STATUS_FULL : sts_pkg::STATUS_DONE;
            out_pos_reg    <= pos[TABLE_DEPTH];
            out_cnt_reg    <= cnt[TABLE_DEPTH] + CNT_W'(tail_grow);
        end
    end

    // port fields are 9 bits; wider counts are masked
    assign pos_ext         = EXT_W'(out_pos_reg);
    assign cnt_ext         = EXT_W'(out_cnt_reg);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = pos_ext[sts_pkg::FIELD_W-1:0];
    assign rsp.entry_count = cnt_ext[sts_pkg::FIELD_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == sts_pkg::OP_INSERT && !table_full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted insert did not grow the table");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == sts_pkg::STATUS_FULL) |-> !out_found_reg)
        else $error("rejected insert reports a hit");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_pos_reg <= out_cnt_reg)
        else $error("position beyond entry count");
`endif

endmodule

// File: src/sts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_cell
// One slot of the sorted table. Holds one entry and one request token stage;
// compares the passing token with its entry, takes part in the insert shift
// and hands the token to the next cell.
// ----------------------------------------------------------------------------
module sts_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 9
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  sts_pkg::sts_tok_t                  tok_in,
    input  logic signed [sts_pkg::VALUE_W-1:0] key_in,
    input  logic signed [sts_pkg::VALUE_W-1:0] carry_in,
    input  logic [CNT_W-1:0]                   pos_in,
    input  logic [CNT_W-1:0]                   cnt_in,
    output sts_pkg::sts_tok_t                  tok_out,
    output logic signed [sts_pkg::VALUE_W-1:0] key_out,
    output logic signed [sts_pkg::VALUE_W-1:0] carry_out,
    output logic [CNT_W-1:0]                   pos_out,
    output logic [CNT_W-1:0]                   cnt_out
);

    logic signed [sts_pkg::VALUE_W-1:0] entry_reg;
    logic signed [sts_pkg::VALUE_W-1:0] entry_next;
    sts_pkg::sts_tok_t                  tok_reg;
    sts_pkg::sts_tok_t                  tok_next;
    logic signed [sts_pkg::VALUE_W-1:0] key_reg;
    logic signed [sts_pkg::VALUE_W-1:0] carry_reg;
    logic signed [sts_pkg::VALUE_W-1:0] carry_next;
    logic [CNT_W-1:0]                   pos_reg;
    logic [CNT_W-1:0]                   pos_next;
    logic [CNT_W-1:0]                   cnt_reg;

    logic occupied;
    logic is_insert;
    logic le_key;
    logic lt_key;
    logic eq_key;
    logic place;
    logic write_en;
    logic pos_inc;

    // slot holds a live entry for this token when it lies below the count
    assign occupied  = cnt_in > CNT_W'(CELL_INDEX);
    assign is_insert = tok_in.op == sts_pkg::OP_INSERT;
    assign le_key    = entry_reg <= key_in;
    assign lt_key    = entry_reg < key_in;
    assign eq_key    = entry_reg == key_in;

    // first slot past every entry <= key takes the new value
    assign place    = is_insert && !tok_in.full && !tok_in.shifting && (!occupied || !le_key);
    assign write_en = adv && tok_in.valid && is_insert && !tok_in.full
                      && (tok_in.shifting || place);
    assign pos_inc  = occupied && (is_insert ? le_key : lt_key);

    always_comb
    begin
        entry_next        = tok_in.shifting ? carry_in : key_in;
        carry_next        = (tok_in.shifting || place) ? entry_reg : carry_in;
        pos_next          = pos_in + CNT_W'(pos_inc);
        tok_next          = tok_in;
        tok_next.shifting = tok_in.shifting || place;
        tok_next.found    = tok_in.found || (occupied && eq_key);
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg   <= key_in;
            carry_reg <= carry_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_in;
        end
    end

    assign tok_out   = tok_reg;
    assign key_out   = key_reg;
    assign carry_out = carry_reg;
    assign pos_out   = pos_reg;
    assign cnt_out   = cnt_reg;

endmodule
